@@ src/cpot_pkg.sv @@
// Shared types, widths and codes for the convex polygon overlap test core.
// No dependencies; every other file in src uses it by scoped names.
`default_nettype none
package cpot_pkg;

  localparam int MAX_V   = 8;
  localparam int COORD_W = 16;
  localparam int IDX_W   = $clog2(MAX_V);
  localparam int CNT_W   = $clog2(MAX_V + 1);
  localparam int AX_W    = COORD_W + 1;
  localparam int PROD_W  = AX_W + COORD_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int GAP_W   = DOT_W + 1;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_TEST   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic             ovf;
  } vst_t;

  typedef struct packed {
    logic v0_ld;
    logic axis_ld;
    logic mul_ld;
    logic mul_y;
    logic add_ld;
    logic cmp_ld;
    logic cmp_first;
    logic cmp_side;
  } dp_ctl_t;

endpackage
`default_nettype wire

@@ src/cpot_vstore.sv @@
// Vertex stores for polygons A and B, fill counts and overflow flag.
// Depends on cpot_pkg.
`default_nettype none
module cpot_vstore (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic                              wr_sel,
  input  wire logic signed [cpot_pkg::COORD_W-1:0] wr_x,
  input  wire logic signed [cpot_pkg::COORD_W-1:0] wr_y,
  input  wire logic                              clr,
  input  wire logic                              rd_sel,
  input  wire logic [cpot_pkg::IDX_W-1:0]        rd_idx,
  output logic signed [cpot_pkg::COORD_W-1:0]    rd_x,
  output logic signed [cpot_pkg::COORD_W-1:0]    rd_y,
  output cpot_pkg::vst_t                         st
);

  logic signed [cpot_pkg::COORD_W-1:0] ax_mem [cpot_pkg::MAX_V];
  logic signed [cpot_pkg::COORD_W-1:0] ay_mem [cpot_pkg::MAX_V];
  logic signed [cpot_pkg::COORD_W-1:0] bx_mem [cpot_pkg::MAX_V];
  logic signed [cpot_pkg::COORD_W-1:0] by_mem [cpot_pkg::MAX_V];

  logic [cpot_pkg::CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [cpot_pkg::CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       a_room, b_room, wr_a, wr_b;
  logic signed [cpot_pkg::COORD_W-1:0] rd_x_r, rd_y_r;

  assign a_room = cnt_a_r < cpot_pkg::CNT_W'(cpot_pkg::MAX_V);
  assign b_room = cnt_b_r < cpot_pkg::CNT_W'(cpot_pkg::MAX_V);
  assign wr_a   = wr_en && (wr_sel == cpot_pkg::SEL_A) && a_room;
  assign wr_b   = wr_en && (wr_sel == cpot_pkg::SEL_B) && b_room;

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    if (clr) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      if (wr_a) cnt_a_nxt = cnt_a_r + cpot_pkg::CNT_W'(1);
      if (wr_b) cnt_b_nxt = cnt_b_r + cpot_pkg::CNT_W'(1);
      if (wr_en && !wr_a && !wr_b) ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      ax_mem[cnt_a_r[cpot_pkg::IDX_W-1:0]] <= wr_x;
      ay_mem[cnt_a_r[cpot_pkg::IDX_W-1:0]] <= wr_y;
    end
    if (wr_b) begin
      bx_mem[cnt_b_r[cpot_pkg::IDX_W-1:0]] <= wr_x;
      by_mem[cnt_b_r[cpot_pkg::IDX_W-1:0]] <= wr_y;
    end
  end

  // registered read: data follows the address in the next cycle
  always_ff @(posedge clk) begin
    if (rd_sel == cpot_pkg::SEL_B) begin
      rd_x_r <= bx_mem[rd_idx];
      rd_y_r <= by_mem[rd_idx];
    end else begin
      rd_x_r <= ax_mem[rd_idx];
      rd_y_r <= ay_mem[rd_idx];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

  assign st.cnt_a = cnt_a_r;
  assign st.cnt_b = cnt_b_r;
  assign st.ovf   = ovf_r;

endmodule
`default_nettype wire

@@ src/cpot_proj.sv @@
// Projection datapath: edge axis, one shared multiplier, accumulate,
// interval min/max for both polygons and the gap sign. Depends on cpot_pkg.
`default_nettype none
module cpot_proj (
  input  wire logic                                clk,
  input  wire cpot_pkg::dp_ctl_t                   ctl,
  input  wire logic signed [cpot_pkg::COORD_W-1:0] rd_x,
  input  wire logic signed [cpot_pkg::COORD_W-1:0] rd_y,
  output logic                                     sep
);

  logic signed [cpot_pkg::COORD_W-1:0] v0x_r, v0y_r;
  logic signed [cpot_pkg::AX_W-1:0]    ax_r, ay_r;
  logic signed [cpot_pkg::PROD_W-1:0]  prod_r, acc_r;
  logic signed [cpot_pkg::DOT_W-1:0]   dot_r;
  logic signed [cpot_pkg::DOT_W-1:0]   lo0_r, hi0_r, lo1_r, hi1_r;
  logic signed [cpot_pkg::PROD_W-1:0]  mul_a, mul_b, prod;
  logic signed [cpot_pkg::DOT_W-1:0]   cur_lo, cur_hi, new_lo, new_hi;
  logic signed [cpot_pkg::GAP_W-1:0]   gap;

  assign mul_a = ctl.mul_y ? cpot_pkg::PROD_W'(ay_r) : cpot_pkg::PROD_W'(ax_r);
  assign mul_b = ctl.mul_y ? cpot_pkg::PROD_W'(rd_y) : cpot_pkg::PROD_W'(rd_x);
  assign prod  = mul_a * mul_b;

  assign cur_lo = ctl.cmp_side ? lo1_r : lo0_r;
  assign cur_hi = ctl.cmp_side ? hi1_r : hi0_r;
  assign new_lo = (ctl.cmp_first || dot_r < cur_lo) ? dot_r : cur_lo;
  assign new_hi = (ctl.cmp_first || dot_r > cur_hi) ? dot_r : cur_hi;

  always_ff @(posedge clk) begin
    if (ctl.v0_ld) begin
      v0x_r <= rd_x;
      v0y_r <= rd_y;
    end
    // axis = perpendicular (-dy, dx) of edge v0 -> v1
    if (ctl.axis_ld) begin
      ax_r <= cpot_pkg::AX_W'(v0y_r) - cpot_pkg::AX_W'(rd_y);
      ay_r <= cpot_pkg::AX_W'(rd_x) - cpot_pkg::AX_W'(v0x_r);
    end
    if (ctl.mul_ld) begin
      prod_r <= prod;
      if (ctl.mul_y) acc_r <= prod_r;
    end
    if (ctl.add_ld) dot_r <= cpot_pkg::DOT_W'(acc_r) + cpot_pkg::DOT_W'(prod_r);
    if (ctl.cmp_ld) begin
      if (ctl.cmp_side) begin
        lo1_r <= new_lo;
        hi1_r <= new_hi;
      end else begin
        lo0_r <= new_lo;
        hi0_r <= new_hi;
      end
    end
  end

  assign gap = (lo0_r < lo1_r)
             ? cpot_pkg::GAP_W'(lo1_r) - cpot_pkg::GAP_W'(hi0_r)
             : cpot_pkg::GAP_W'(lo0_r) - cpot_pkg::GAP_W'(hi1_r);
  assign sep = !gap[cpot_pkg::GAP_W-1] && (gap != '0);

endmodule
`default_nettype wire

@@ src/cpot_ctrl.sv @@
// Sequencer for the separating-axis walk: edges of A then B, projections of
// both polygons per edge through the shared datapath. Depends on cpot_pkg.
`default_nettype none
module cpot_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        test_go,
  input  wire cpot_pkg::vst_t              st,
  input  wire logic                        sep,
  input  wire logic                        out_full,
  output logic                             busy,
  output logic                             rd_sel,
  output logic [cpot_pkg::IDX_W-1:0]       rd_idx,
  output cpot_pkg::dp_ctl_t                ctl,
  output logic                             out_ld,
  output logic                             res_hit,
  output logic [1:0]                       res_status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE0 = 4'd1;
  localparam logic [3:0] S_EDGE1 = 4'd2;
  localparam logic [3:0] S_MULX  = 4'd3;
  localparam logic [3:0] S_MULY  = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_GAP   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic                       pass_r, pass_nxt;
  logic                       side_r, side_nxt;
  logic [cpot_pkg::IDX_W-1:0] edge_r, edge_nxt;
  logic [cpot_pkg::IDX_W-1:0] vtx_r, vtx_nxt;
  logic                       hit_r, hit_nxt;
  logic [1:0]                 status_r, status_nxt;

  logic [cpot_pkg::CNT_W-1:0] np, nq, ncur, edge_inc, vtx_inc;
  logic                       last_edge, last_vtx;

  assign np        = pass_r ? st.cnt_b : st.cnt_a;
  assign nq        = pass_r ? st.cnt_a : st.cnt_b;
  assign ncur      = side_r ? nq : np;
  assign edge_inc  = cpot_pkg::CNT_W'(edge_r) + cpot_pkg::CNT_W'(1);
  assign vtx_inc   = cpot_pkg::CNT_W'(vtx_r) + cpot_pkg::CNT_W'(1);
  assign last_edge = edge_inc >= np;
  assign last_vtx  = vtx_inc >= ncur;

  // each state addresses the vertex that the next state consumes
  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    side_nxt   = side_r;
    edge_nxt   = edge_r;
    vtx_nxt    = vtx_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    rd_sel     = pass_r;
    rd_idx     = '0;
    ctl        = '0;
    out_ld     = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_sel = cpot_pkg::SEL_A;
        if (test_go) begin
          if (st.cnt_a == '0 || st.cnt_b == '0) begin
            hit_nxt    = 1'b0;
            status_nxt = cpot_pkg::ST_EMPTY;
            state_nxt  = S_FIN;
          end else begin
            status_nxt = st.ovf ? cpot_pkg::ST_OVF : cpot_pkg::ST_OK;
            pass_nxt   = 1'b0;
            edge_nxt   = '0;
            state_nxt  = S_EDGE0;
          end
        end
      end
      S_EDGE0: begin
        rd_idx    = last_edge ? '0 : edge_inc[cpot_pkg::IDX_W-1:0];
        ctl.v0_ld = 1'b1;
        state_nxt = S_EDGE1;
      end
      S_EDGE1: begin
        rd_idx      = '0;
        ctl.axis_ld = 1'b1;
        side_nxt    = 1'b0;
        vtx_nxt     = '0;
        state_nxt   = S_MULX;
      end
      S_MULX: begin
        rd_sel     = pass_r ^ side_r;
        rd_idx     = vtx_r;
        ctl.mul_ld = 1'b1;
        state_nxt  = S_MULY;
      end
      S_MULY: begin
        ctl.mul_ld = 1'b1;
        ctl.mul_y  = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        ctl.add_ld = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        ctl.cmp_ld    = 1'b1;
        ctl.cmp_first = (vtx_r == '0);
        ctl.cmp_side  = side_r;
        if (!last_vtx) begin
          rd_sel    = pass_r ^ side_r;
          rd_idx    = vtx_inc[cpot_pkg::IDX_W-1:0];
          vtx_nxt   = vtx_inc[cpot_pkg::IDX_W-1:0];
          state_nxt = S_MULX;
        end else if (!side_r) begin
          rd_sel    = !pass_r;
          rd_idx    = '0;
          side_nxt  = 1'b1;
          vtx_nxt   = '0;
          state_nxt = S_MULX;
        end else begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        if (sep) begin
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if (!last_edge) begin
          rd_idx    = edge_inc[cpot_pkg::IDX_W-1:0];
          edge_nxt  = edge_inc[cpot_pkg::IDX_W-1:0];
          state_nxt = S_EDGE0;
        end else if (!pass_r) begin
          rd_sel    = cpot_pkg::SEL_B;
          rd_idx    = '0;
          pass_nxt  = 1'b1;
          edge_nxt  = '0;
          state_nxt = S_EDGE0;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_full) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r   <= pass_nxt;
    side_r   <= side_nxt;
    edge_r   <= edge_nxt;
    vtx_r    <= vtx_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign res_hit    = hit_r;
  assign res_status = status_r;

endmodule
`default_nettype wire

@@ src/convex_polygon_overlap_test_core.sv @@
// Top level of the convex polygon overlap test core.
// Depends on cpot_pkg, cpot_vstore, cpot_proj and cpot_ctrl.
`default_nettype none
// A load beat (func 0 or 1) stores one vertex and gives no result; a
// vertex beyond eight per polygon is dropped and flagged in the next
// status. A test beat (func 2) walks every edge of A and then of B through
// one shared multiplier, stopping at the first axis that separates them,
// and walks no edge when a polygon is empty. The input is stalled while
// a test runs. Each test gives one result beat and empties both polygons.
// func 3 is ignored.
module convex_polygon_overlap_test_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic signed [15:0] in_vert_x,
  input  wire logic signed [15:0] in_vert_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_intersects,
  output logic [1:0]       out_status
);

  logic                                 in_acc, busy, out_full, out_ld;
  logic                                 rd_sel, sep, res_hit;
  logic [1:0]                           res_status;
  logic [cpot_pkg::IDX_W-1:0]           rd_idx;
  logic signed [cpot_pkg::COORD_W-1:0]  rd_x, rd_y;
  cpot_pkg::vst_t                       st;
  cpot_pkg::dp_ctl_t                    ctl;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_hit_r;
  logic [1:0]                           out_status_r;

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign out_full = out_valid_r && out_stall;

  cpot_vstore u_vstore (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc && (in_func inside {cpot_pkg::FUNC_LOAD_A, cpot_pkg::FUNC_LOAD_B})),
    .wr_sel (in_func[0]),
    .wr_x   (in_vert_x),
    .wr_y   (in_vert_y),
    .clr    (out_ld),
    .rd_sel (rd_sel),
    .rd_idx (rd_idx),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .st     (st)
  );

  cpot_proj u_proj (
    .clk  (clk),
    .ctl  (ctl),
    .rd_x (rd_x),
    .rd_y (rd_y),
    .sep  (sep)
  );

  cpot_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .test_go    (in_acc && in_func == cpot_pkg::FUNC_TEST),
    .st         (st),
    .sep        (sep),
    .out_full   (out_full),
    .busy       (busy),
    .rd_sel     (rd_sel),
    .rd_idx     (rd_idx),
    .ctl        (ctl),
    .out_ld     (out_ld),
    .res_hit    (res_hit),
    .res_status (res_status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_hit_r    <= res_hit;
      out_status_r <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_hit_r;
  assign out_status     = out_status_r;

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (st.cnt_a == '0 && st.cnt_b == '0 && !st.ovf))
    else $error("polygon stores not emptied after a test");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == cpot_pkg::ST_OK || out_status == cpot_pkg::ST_EMPTY ||
                   out_status == cpot_pkg::ST_OVF))
    else $error("reserved status code on result beat");

  a_empty_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cpot_pkg::ST_EMPTY) |-> !out_intersects)
    else $error("empty polygon reported as intersecting");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !out_ld) |=> ($stable(st.cnt_a) && $stable(st.cnt_b)))
    else $error("vertex store changed during a test");

endmodule
`default_nettype wire
